@@ hdl/aadi_pkg.sv @@
// Shared types and constants for the audio and aux-memory DMA interface block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package aadi_pkg;

   // Bytes fetched per audio tick.
   localparam int BLOCK_BYTES = 32;

   // Action codes of a request transaction.
   localparam logic [1:0] ACT_READ  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_TICK  = 2'd2;
   localparam logic [1:0] ACT_EVENT = 2'd3;

   // Interrupt source codes.
   localparam logic [1:0] SRC_DSP   = 2'd0;
   localparam logic [1:0] SRC_AUX   = 2'd1;
   localparam logic [1:0] SRC_AUDIO = 2'd2;

   // Register offsets.
   localparam logic [15:0] OFF_CONTROL    = 16'h500A;
   localparam logic [15:0] OFF_AUX_MODE   = 16'h5012;
   localparam logic [15:0] OFF_READY      = 16'h5016;
   localparam logic [15:0] OFF_MAIN_HI    = 16'h5020;
   localparam logic [15:0] OFF_MAIN_LO    = 16'h5022;
   localparam logic [15:0] OFF_AUX_HI     = 16'h5024;
   localparam logic [15:0] OFF_AUX_LO     = 16'h5026;
   localparam logic [15:0] OFF_COUNT_HI   = 16'h5028;
   localparam logic [15:0] OFF_COUNT_LO   = 16'h502A;
   localparam logic [15:0] OFF_SRC_HI     = 16'h5030;
   localparam logic [15:0] OFF_SRC_LO     = 16'h5032;
   localparam logic [15:0] OFF_AUDIO_CTRL = 16'h5036;
   localparam logic [15:0] OFF_BLOCKS     = 16'h503A;

   // Control/status register fields and reset values.
   localparam logic [15:0] CTRL_KEEP_WRITTEN = 16'hFD57;
   localparam logic [15:0] CTRL_STATUS_BITS  = 16'h00A8;
   localparam logic [15:0] ST_AUDIO          = 16'h0008;
   localparam logic [15:0] ST_AUX            = 16'h0020;
   localparam logic [15:0] ST_DSP            = 16'h0080;
   localparam logic [15:0] CTRL_RESET_VALUE  = 16'h0004;
   localparam logic [15:0] AUX_MODE_RESET    = 16'h0043;
   localparam logic [15:0] READY_FLAG        = 16'h0001;

   // Bit masks of the count-half tracker.
   localparam logic [1:0] HALF_HIGH = 2'b01;
   localparam logic [1:0] HALF_LOW  = 2'b10;
   localparam logic [1:0] HALF_BOTH = 2'b11;

   typedef struct packed {
      logic [1:0]  action;
      logic [15:0] reg_offset;
      logic        wide_access;
      logic [31:0] write_data;
      logic [1:0]  int_source;
      logic        int_level;
   } req_type;

   typedef struct packed {
      logic [31:0] read_data;
      logic        irq;
      logic        audio_fetch_valid;
      logic [31:0] audio_fetch_addr;
      logic        dma_start;
      logic        dma_to_main;
      logic [30:0] dma_length;
      logic [31:0] dma_main_addr;
      logic [31:0] dma_aux_addr;
   } rsp_type;

endpackage

`default_nettype wire

@@ hdl/aadi_if.sv @@
// Valid/ready channel interfaces for the request and response transactions.
// Depends on aadi_pkg for the payload types.
`default_nettype none

interface aadi_req_if
   import aadi_pkg::*;
   ();
   logic    valid;
   logic    ready;
   req_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface aadi_rsp_if
   import aadi_pkg::*;
   ();
   logic    valid;
   logic    ready;
   rsp_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

@@ hdl/aadi_core.sv @@
// Register file and per-transaction update logic of the DMA interface block.
// Depends on aadi_pkg; instantiated by audio_and_aux_dma_interface_top.
`default_nettype none

module aadi_core
   import aadi_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    fire,
   input  wire req_type item,
   output rsp_type      result
);

   logic [15:0] control_status_ff, control_status_in;
   logic [15:0] aux_mode_ff, aux_mode_in;
   logic [31:0] main_addr_ff, main_addr_in;
   logic [31:0] aux_addr_ff, aux_addr_in;
   logic [31:0] count_ff, count_in;
   logic [1:0]  half_written_ff, half_written_in;
   logic [31:0] audio_source_ff, audio_source_in;
   logic [31:0] read_ptr_ff, read_ptr_in;
   logic [15:0] audio_control_ff, audio_control_in;
   logic [14:0] blocks_ff, blocks_in;

   always_comb begin
      logic [15:0] v;
      logic [15:0] status_bit;
      logic [14:0] blocks_dec;
      logic        dma_fire;

      v          = item.write_data[15:0];
      status_bit = '0;
      blocks_dec = blocks_ff - 15'd1;
      dma_fire   = 1'b0;

      control_status_in = control_status_ff;
      aux_mode_in       = aux_mode_ff;
      main_addr_in      = main_addr_ff;
      aux_addr_in       = aux_addr_ff;
      count_in          = count_ff;
      half_written_in   = half_written_ff;
      audio_source_in   = audio_source_ff;
      read_ptr_in       = read_ptr_ff;
      audio_control_in  = audio_control_ff;
      blocks_in         = blocks_ff;
      result            = '0;

      unique case (item.action)
         ACT_READ: begin
            if (!item.wide_access) begin
               unique case (item.reg_offset)
                  OFF_CONTROL:    result.read_data = {16'd0, control_status_ff};
                  OFF_AUX_MODE:   result.read_data = {16'd0, aux_mode_ff};
                  OFF_READY:      result.read_data = {16'd0, READY_FLAG};
                  OFF_MAIN_HI:    result.read_data = {16'd0, main_addr_ff[31:16]};
                  OFF_MAIN_LO:    result.read_data = {16'd0, main_addr_ff[15:0]};
                  OFF_AUX_HI:     result.read_data = {16'd0, aux_addr_ff[31:16]};
                  OFF_AUX_LO:     result.read_data = {16'd0, aux_addr_ff[15:0]};
                  OFF_COUNT_HI:   result.read_data = {16'd0, count_ff[31:16]};
                  OFF_COUNT_LO:   result.read_data = {16'd0, count_ff[15:0]};
                  OFF_SRC_HI:     result.read_data = {16'd0, audio_source_ff[31:16]};
                  OFF_SRC_LO:     result.read_data = {16'd0, audio_source_ff[15:0]};
                  OFF_AUDIO_CTRL: result.read_data = {16'd0, audio_control_ff};
                  OFF_BLOCKS:     result.read_data = {17'd0, blocks_ff};
                  default:        result.read_data = '0;
               endcase
            end
         end

         ACT_WRITE: begin
            if (item.wide_access) begin
               unique case (item.reg_offset)
                  OFF_MAIN_HI: main_addr_in = item.write_data;
                  OFF_AUX_HI:  aux_addr_in  = item.write_data;
                  OFF_COUNT_HI: begin
                     count_in        = item.write_data;
                     half_written_in = HALF_BOTH;
                  end
                  default: ;
               endcase
            end else begin
               unique case (item.reg_offset)
                  OFF_CONTROL: control_status_in = (v & CTRL_KEEP_WRITTEN) |
                     (control_status_ff & CTRL_STATUS_BITS & ~v);
                  OFF_AUX_MODE: aux_mode_in = v;
                  OFF_MAIN_HI:  main_addr_in[31:16] = v;
                  OFF_MAIN_LO:  main_addr_in[15:0]  = v;
                  OFF_AUX_HI:   aux_addr_in[31:16]  = v;
                  OFF_AUX_LO:   aux_addr_in[15:0]   = v;
                  OFF_COUNT_HI: begin
                     count_in[31:16] = v;
                     half_written_in = half_written_ff | HALF_HIGH;
                  end
                  OFF_COUNT_LO: begin
                     count_in[15:0]  = v;
                     half_written_in = half_written_ff | HALF_LOW;
                  end
                  OFF_SRC_HI: audio_source_in[31:16] = v;
                  OFF_SRC_LO: audio_source_in[15:0]  = v;
                  OFF_AUDIO_CTRL: begin
                     audio_control_in = v;
                     // Enable going high starts a new run.
                     if (!audio_control_ff[15] && v[15]) begin
                        blocks_in         = v[14:0];
                        read_ptr_in       = audio_source_ff;
                        control_status_in = control_status_ff | ST_AUDIO;
                     end
                  end
                  default: ;
               endcase
            end
            // Only count writes can complete both halves, and the control
            // register is never written by the same transaction.
            dma_fire = (half_written_in == HALF_BOTH);
            if (dma_fire) begin
               half_written_in      = '0;
               result.dma_start     = 1'b1;
               result.dma_to_main   = count_in[31];
               result.dma_length    = count_in[30:0];
               result.dma_main_addr = main_addr_ff;
               result.dma_aux_addr  = aux_addr_ff;
               count_in             = {count_in[31], 31'd0};
               control_status_in    = control_status_in | ST_AUX;
            end
         end

         ACT_TICK: begin
            if (audio_control_ff[15] && (blocks_ff != '0)) begin
               result.audio_fetch_valid = 1'b1;
               result.audio_fetch_addr  = read_ptr_ff;
               if (blocks_dec == '0) begin
                  blocks_in         = audio_control_ff[14:0];
                  read_ptr_in       = audio_source_ff;
                  control_status_in = control_status_ff | ST_AUDIO;
               end else begin
                  blocks_in   = blocks_dec;
                  read_ptr_in = read_ptr_ff + 32'(BLOCK_BYTES);
               end
            end
         end

         ACT_EVENT: begin
            unique case (item.int_source)
               SRC_DSP:   status_bit = ST_DSP;
               SRC_AUX:   status_bit = ST_AUX;
               SRC_AUDIO: status_bit = ST_AUDIO;
               default:   status_bit = '0;
            endcase
            if (item.int_level) begin
               control_status_in = control_status_ff | status_bit;
            end else begin
               control_status_in = control_status_ff & ~status_bit;
            end
         end

         default: ;
      endcase

      result.irq = (control_status_in[3] & control_status_in[4]) |
                   (control_status_in[5] & control_status_in[6]) |
                   (control_status_in[7] & control_status_in[8]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         control_status_ff <= CTRL_RESET_VALUE;
         aux_mode_ff       <= AUX_MODE_RESET;
         main_addr_ff      <= '0;
         aux_addr_ff       <= '0;
         count_ff          <= '0;
         half_written_ff   <= '0;
         audio_source_ff   <= '0;
         read_ptr_ff       <= '0;
         audio_control_ff  <= '0;
         blocks_ff         <= '0;
      end else if (fire) begin
         control_status_ff <= control_status_in;
         aux_mode_ff       <= aux_mode_in;
         main_addr_ff      <= main_addr_in;
         aux_addr_ff       <= aux_addr_in;
         count_ff          <= count_in;
         half_written_ff   <= half_written_in;
         audio_source_ff   <= audio_source_in;
         read_ptr_ff       <= read_ptr_in;
         audio_control_ff  <= audio_control_in;
         blocks_ff         <= blocks_in;
      end
   end

endmodule

`default_nettype wire

@@ hdl/audio_and_aux_dma_interface_top.sv @@
// A response appears in the cycle after its request transaction is accepted.
// Throughput: one request transaction per cycle, limited only by the response sink.
// A request is taken whenever the response register is empty or being drained.
// Reset (synchronous, active high) empties the response register and returns all
// registers to their defaults: control/status 0x0004 (halt), aux mode 0x43, rest 0.
// Depends on aadi_pkg, aadi_if.sv and aadi_core.sv.
`default_nettype none

module audio_and_aux_dma_interface_top
   import aadi_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   aadi_req_if.sink   req_ch,
   aadi_rsp_if.source rsp_ch
);

   // The response register holds one finished transaction. Because a new
   // request may enter in the same cycle that the held response is taken,
   // back-to-back traffic flows at full rate with no bubble.
   logic    rsp_valid_ff, rsp_valid_in;
   rsp_type rsp_data_ff;
   rsp_type core_result;
   logic    fire;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign fire         = req_ch.valid && req_ch.ready;

   // All register updates and response fields for one transaction are worked
   // out in a single pass inside the core and committed on acceptance.
   aadi_core u_core (
      .clock  (clock),
      .reset  (reset),
      .fire   (fire),
      .item   (req_ch.payload),
      .result (core_result)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // The payload register needs no reset; it is qualified by the valid flag.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_data_ff <= core_result;
      end
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_data_ff;

endmodule

`default_nettype wire

@@ test/aadi_response_check.sv @@
`timescale 1ns / 100ps
// Response checker for the audio and aux-memory DMA interface block: watches both channels,
// keeps its own copy of the register state and compares every response field by field.
// Depends on aadi_pkg and the channel interfaces in aadi_if.sv.

module aadi_response_check
   import aadi_pkg::*;
(
   input  logic clock,
   input  logic reset,
   aadi_req_if  req_mon,
   aadi_rsp_if  rsp_mon,
   output int   fail_count,
   output int   pending,
   output int   responses_seen,
   output int   fetch_count,
   output int   dma_count,
   output int   read_count,
   output int   irq_count
);

   logic [15:0] ctl_stat;
   logic [15:0] aux_mode_val;
   logic [31:0] main_addr;
   logic [31:0] aux_addr;
   logic [31:0] xfer_count;
   logic [1:0]  halves_seen;
   logic [31:0] audio_src;
   logic [31:0] audio_ptr;
   logic [15:0] audio_ctl;
   logic [14:0] blocks_left;

   rsp_type due_responses[$];

   int fails = 0;
   int seen = 0;
   int fetches = 0;
   int dmas = 0;
   int reads = 0;
   int irqs = 0;

   function automatic void clear_registers();
      ctl_stat     = CTRL_RESET_VALUE;
      aux_mode_val = AUX_MODE_RESET;
      main_addr    = '0;
      aux_addr     = '0;
      xfer_count   = '0;
      halves_seen  = '0;
      audio_src    = '0;
      audio_ptr    = '0;
      audio_ctl    = '0;
      blocks_left  = '0;
   endfunction

   // Applies one transaction to the register copy and returns the response it causes.
   function automatic rsp_type advance_registers(req_type t);
      rsp_type     r;
      logic [15:0] v;
      logic [15:0] src_bit;
      logic        was_on;
      r = '0;
      v = t.write_data[15:0];
      case (t.action)
         ACT_READ: begin
            if (!t.wide_access) begin
               case (t.reg_offset)
                  OFF_CONTROL:    r.read_data = {16'h0, ctl_stat};
                  OFF_AUX_MODE:   r.read_data = {16'h0, aux_mode_val};
                  OFF_READY:      r.read_data = {16'h0, READY_FLAG};
                  OFF_MAIN_HI:    r.read_data = {16'h0, main_addr[31:16]};
                  OFF_MAIN_LO:    r.read_data = {16'h0, main_addr[15:0]};
                  OFF_AUX_HI:     r.read_data = {16'h0, aux_addr[31:16]};
                  OFF_AUX_LO:     r.read_data = {16'h0, aux_addr[15:0]};
                  OFF_COUNT_HI:   r.read_data = {16'h0, xfer_count[31:16]};
                  OFF_COUNT_LO:   r.read_data = {16'h0, xfer_count[15:0]};
                  OFF_SRC_HI:     r.read_data = {16'h0, audio_src[31:16]};
                  OFF_SRC_LO:     r.read_data = {16'h0, audio_src[15:0]};
                  OFF_AUDIO_CTRL: r.read_data = {16'h0, audio_ctl};
                  OFF_BLOCKS:     r.read_data = {17'h0, blocks_left};
                  default:        r.read_data = '0;
               endcase
            end
         end
         ACT_WRITE: begin
            if (t.wide_access) begin
               case (t.reg_offset)
                  OFF_MAIN_HI: main_addr = t.write_data;
                  OFF_AUX_HI:  aux_addr = t.write_data;
                  OFF_COUNT_HI: begin
                     xfer_count  = t.write_data;
                     halves_seen = HALF_BOTH;
                  end
                  default: ;
               endcase
            end else begin
               case (t.reg_offset)
                  OFF_CONTROL:
                     ctl_stat = (v & CTRL_KEEP_WRITTEN) | (ctl_stat & CTRL_STATUS_BITS & ~v);
                  OFF_AUX_MODE: aux_mode_val = v;
                  OFF_MAIN_HI:  main_addr[31:16] = v;
                  OFF_MAIN_LO:  main_addr[15:0] = v;
                  OFF_AUX_HI:   aux_addr[31:16] = v;
                  OFF_AUX_LO:   aux_addr[15:0] = v;
                  OFF_COUNT_HI: begin
                     xfer_count[31:16] = v;
                     halves_seen = halves_seen | HALF_HIGH;
                  end
                  OFF_COUNT_LO: begin
                     xfer_count[15:0] = v;
                     halves_seen = halves_seen | HALF_LOW;
                  end
                  OFF_SRC_HI:   audio_src[31:16] = v;
                  OFF_SRC_LO:   audio_src[15:0] = v;
                  OFF_AUDIO_CTRL: begin
                     was_on    = audio_ctl[15];
                     audio_ctl = v;
                     if (!was_on && v[15]) begin
                        blocks_left = v[14:0];
                        audio_ptr   = audio_src;
                        ctl_stat    = ctl_stat | ST_AUDIO;
                     end
                  end
                  default: ;
               endcase
            end
            // Only a count write can complete both halves, so this fires right after one.
            if (halves_seen == HALF_BOTH) begin
               halves_seen     = '0;
               r.dma_start     = 1'b1;
               r.dma_to_main   = xfer_count[31];
               r.dma_length    = xfer_count[30:0];
               r.dma_main_addr = main_addr;
               r.dma_aux_addr  = aux_addr;
               xfer_count      = xfer_count & 32'h8000_0000;
               ctl_stat        = ctl_stat | ST_AUX;
            end
         end
         ACT_TICK: begin
            if (audio_ctl[15] && blocks_left != '0) begin
               r.audio_fetch_valid = 1'b1;
               r.audio_fetch_addr  = audio_ptr;
               audio_ptr   = audio_ptr + 32'(BLOCK_BYTES);
               blocks_left = blocks_left - 15'd1;
               if (blocks_left == '0) begin
                  blocks_left = audio_ctl[14:0];
                  audio_ptr   = audio_src;
                  ctl_stat    = ctl_stat | ST_AUDIO;
               end
            end
         end
         default: begin
            case (t.int_source)
               SRC_DSP:   src_bit = ST_DSP;
               SRC_AUX:   src_bit = ST_AUX;
               SRC_AUDIO: src_bit = ST_AUDIO;
               default:   src_bit = '0;
            endcase
            if (t.int_level) ctl_stat = ctl_stat | src_bit;
            else ctl_stat = ctl_stat & ~src_bit;
         end
      endcase
      // Each mask bit sits one place above its status bit.
      r.irq = |(ctl_stat & CTRL_STATUS_BITS & (ctl_stat >> 1));
      return r;
   endfunction

   task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", field, want, got);
         fails++;
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      rsp_type got;
      if (reset) begin
         clear_registers();
         due_responses.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = rsp_mon.payload;
            seen++;
            if (got.irq === 1'b1) irqs++;
            if (due_responses.size() == 0) begin
               $error("response transaction arrived with no request outstanding");
               fails++;
            end else begin
               want = due_responses.pop_front();
               compare_field("read_data", want.read_data, got.read_data);
               compare_field("irq", 32'(want.irq), 32'(got.irq));
               compare_field("audio_fetch_valid", 32'(want.audio_fetch_valid),
                             32'(got.audio_fetch_valid));
               compare_field("audio_fetch_addr", want.audio_fetch_addr, got.audio_fetch_addr);
               compare_field("dma_start", 32'(want.dma_start), 32'(got.dma_start));
               compare_field("dma_to_main", 32'(want.dma_to_main), 32'(got.dma_to_main));
               compare_field("dma_length", 32'(want.dma_length), 32'(got.dma_length));
               compare_field("dma_main_addr", want.dma_main_addr, got.dma_main_addr);
               compare_field("dma_aux_addr", want.dma_aux_addr, got.dma_aux_addr);
               if (want.audio_fetch_valid) fetches++;
               if (want.dma_start) dmas++;
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            if (req_mon.payload.action == ACT_READ) reads++;
            due_responses.push_back(advance_registers(req_mon.payload));
         end
      end
      fail_count     <= fails;
      pending        <= due_responses.size();
      responses_seen <= seen;
      fetch_count    <= fetches;
      dma_count      <= dmas;
      read_count     <= reads;
      irq_count      <= irqs;
   end

endmodule

@@ test/tb_top.sv @@
`timescale 1ns / 100ps
// Top of the testbench for audio_and_aux_dma_interface_top: clock, reset, stimulus, the
// response sink and the verdict. Depends on aadi_pkg, aadi_if.sv and aadi_response_check.sv.

module tb_top;
   import aadi_pkg::*;

   // Offsets the package does not name: the four mailbox words and a spare that reads zero.
   localparam logic [15:0] OFF_MAILBOX0 = 16'h5000;
   localparam logic [15:0] OFF_MAILBOX1 = 16'h5002;
   localparam logic [15:0] OFF_MAILBOX2 = 16'h5004;
   localparam logic [15:0] OFF_MAILBOX3 = 16'h5006;
   localparam logic [15:0] OFF_SPARE    = 16'h501A;

   // Source code three names no interrupt source and must leave the status bits alone.
   localparam logic [1:0] SRC_NONE = 2'd3;

   localparam int REG_COUNT = 18;
   localparam logic [15:0] REG_MAP [REG_COUNT] = '{
      OFF_MAILBOX0, OFF_MAILBOX1, OFF_MAILBOX2, OFF_MAILBOX3, OFF_CONTROL, OFF_AUX_MODE,
      OFF_READY, OFF_SPARE, OFF_MAIN_HI, OFF_MAIN_LO, OFF_AUX_HI, OFF_AUX_LO, OFF_COUNT_HI,
      OFF_COUNT_LO, OFF_SRC_HI, OFF_SRC_LO, OFF_AUDIO_CTRL, OFF_BLOCKS
   };

   localparam int ITEM_TARGET  = 1850;
   localparam int IDLE_PERCENT = 29;
   // Both sides stop idling for this range of transactions.
   localparam int CALM_FROM    = 900;
   localparam int CALM_TO      = 1200;
   // After this many transactions the response sink holds off for a long stretch.
   localparam int HOLD_AT      = 500;
   localparam int HOLD_CYCLES  = 300;
   // The watchdog gives up after this many cycles without any accepted transaction;
   // it sits well above the long hold-off and any random stall.
   localparam int STALL_LIMIT  = 2000;
   // The block answers in the cycle after acceptance, so this tail is plenty.
   localparam int TAIL_CYCLES  = 4;

   logic clock;
   logic reset;

   aadi_req_if req_ch ();
   aadi_rsp_if rsp_ch ();

   int fail_count;
   int pending;
   int responses_seen;
   int fetch_count;
   int dma_count;
   int read_count;
   int irq_count;

   int items_sent = 0;
   int quiet_cycles = 0;
   int hold_requests = 0;
   int holds_done = 0;
   bit calm = 1'b0;

   audio_and_aux_dma_interface_top dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   aadi_response_check response_check (
      .clock          (clock),
      .reset          (reset),
      .req_mon        (req_ch),
      .rsp_mon        (rsp_ch),
      .fail_count     (fail_count),
      .pending        (pending),
      .responses_seen (responses_seen),
      .fetch_count    (fetch_count),
      .dma_count      (dma_count),
      .read_count     (read_count),
      .irq_count      (irq_count)
   );

   // 4 ns period.
   always begin
      clock = 1'b0;
      #2;
      clock = 1'b1;
      #2;
   end

   // Builds a bus access, tick or other non-event transaction. The interrupt fields are
   // ignored by such transactions, so they carry random values.
   function automatic req_type access(logic [1:0] act, logic [15:0] off, logic wide,
                                      logic [31:0] data);
      req_type t;
      t.action      = act;
      t.reg_offset  = off;
      t.wide_access = wide;
      t.write_data  = data;
      t.int_source  = 2'($urandom_range(0, 3));
      t.int_level   = 1'($urandom_range(0, 1));
      return t;
   endfunction

   // Builds an interrupt event; the bus fields are don't-cares and get random values.
   function automatic req_type irq_event(logic [1:0] src, logic level);
      req_type t;
      t = access(ACT_EVENT, 16'($urandom()), 1'($urandom_range(0, 1)), $urandom());
      t.int_source = src;
      t.int_level  = level;
      return t;
   endfunction

   // Offers one transaction, idling first at random outside the calm stretch, and returns
   // at the edge where the block accepts it. Valid stays high into the next transaction
   // unless an idle cycle is chosen, so each step sees a single assignment to it.
   task automatic offer(input req_type item);
      while (!calm && $urandom_range(0, 99) < IDLE_PERCENT) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= item;
      do @(posedge clock); while (!req_ch.ready);
      items_sent++;
   endtask

   // Response sink. It stalls at random except in the calm stretch, and once holds off for
   // HOLD_CYCLES in a row so the response register fills and the request side backs up.
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (holds_done < hold_requests) begin
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            holds_done++;
         end
         rsp_ch.ready <= calm || ($urandom_range(0, 99) >= IDLE_PERCENT);
      end
   end

   // Watchdog: counts cycles in which neither channel completes a transaction.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("audio_and_aux_dma_interface_top: mismatch");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int          pick;
      int          n;
      logic [31:0] data;
      logic [14:0] blocks;

      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part. Reset values first, including a wide read, which always answers zero.
      offer(access(ACT_READ, OFF_CONTROL, 1'b0, 32'h0));
      offer(access(ACT_READ, OFF_AUX_MODE, 1'b0, 32'h0));
      offer(access(ACT_READ, OFF_READY, 1'b0, 32'h0));
      offer(access(ACT_READ, OFF_CONTROL, 1'b1, 32'h0));
      // All ones into control: every mask and plugin bit set, status bits cleared.
      offer(access(ACT_WRITE, OFF_CONTROL, 1'b0, 32'hFFFF_FFFF));
      // Raise each source in turn, try the unused source code, then drop one again.
      offer(irq_event(SRC_DSP, 1'b1));
      offer(irq_event(SRC_AUX, 1'b1));
      offer(irq_event(SRC_AUDIO, 1'b1));
      offer(irq_event(SRC_NONE, 1'b1));
      offer(irq_event(SRC_DSP, 1'b0));
      // Clear the remaining status bits by writing ones to them, masks go low.
      offer(access(ACT_WRITE, OFF_CONTROL, 1'b0, 32'h0000_00A8));
      // Aux DMA: a wide count write with every bit set, then the two halves in reverse order.
      offer(access(ACT_WRITE, OFF_MAIN_HI, 1'b1, 32'hFFFF_FFFF));
      offer(access(ACT_WRITE, OFF_COUNT_HI, 1'b1, 32'hFFFF_FFFF));
      offer(access(ACT_WRITE, OFF_COUNT_LO, 1'b0, 32'h0));
      offer(access(ACT_WRITE, OFF_COUNT_HI, 1'b0, 32'h0000_7FFF));
      // A wide write to the audio source is ignored; the narrow halves take effect.
      offer(access(ACT_WRITE, OFF_SRC_HI, 1'b1, 32'h1234_5678));
      offer(access(ACT_WRITE, OFF_SRC_HI, 1'b0, 32'hABCD_FFFF));
      offer(access(ACT_WRITE, OFF_SRC_LO, 1'b0, 32'h0000_FFE0));
      // An enabled run of zero blocks never fetches.
      offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, 32'h0000_8000));
      offer(access(ACT_TICK, 16'h0, 1'b0, 32'h0));
      // Largest run: the second fetch address wraps around the top of memory.
      offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, 32'h0));
      offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, 32'h0000_FFFF));
      offer(access(ACT_TICK, 16'h0, 1'b0, 32'h0));
      offer(access(ACT_TICK, 16'h0, 1'b0, 32'h0));
      // A one-block run ends on its first tick and reloads.
      offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, 32'h0));
      offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, 32'h0000_8001));
      offer(access(ACT_TICK, 16'h0, 1'b0, 32'h0));
      offer(access(ACT_WRITE, OFF_MAILBOX0, 1'b0, 32'hFFFF_FFFF));
      offer(access(ACT_READ, OFF_BLOCKS, 1'b0, 32'h0));

      // Random part: mostly well-formed audio runs and DMA setups with random content,
      // mixed with control writes, interrupt events, reads and plain noise.
      while (items_sent < ITEM_TARGET) begin
         calm = (items_sent >= CALM_FROM) && (items_sent < CALM_TO);
         if (items_sent >= HOLD_AT && hold_requests == 0) hold_requests = 1;
         pick = $urandom_range(0, 99);
         if (pick < 22) begin
            offer(access(ACT_WRITE, OFF_SRC_HI, 1'b0, $urandom()));
            offer(access(ACT_WRITE, OFF_SRC_LO, 1'b0, $urandom()));
            data = $urandom();
            data[15] = 1'b0;
            offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, data));
            // Mostly short runs so they wrap often; now and then a long one.
            if ($urandom_range(0, 9) == 0) blocks = 15'($urandom());
            else blocks = 15'($urandom_range(0, 5));
            data = $urandom();
            data[15] = 1'b1;
            data[14:0] = blocks;
            offer(access(ACT_WRITE, OFF_AUDIO_CTRL, 1'b0, data));
            n = $urandom_range(1, 14);
            repeat (n) begin
               if ($urandom_range(0, 4) == 0)
                  offer(access(ACT_READ, $urandom_range(0, 1) ? OFF_BLOCKS : OFF_CONTROL,
                               1'b0, $urandom()));
               else
                  offer(access(ACT_TICK, 16'($urandom()), 1'($urandom_range(0, 1)),
                               $urandom()));
            end
         end else if (pick < 42) begin
            if ($urandom_range(0, 1)) begin
               offer(access(ACT_WRITE, OFF_MAIN_HI, 1'b1, $urandom()));
            end else begin
               offer(access(ACT_WRITE, OFF_MAIN_HI, 1'b0, $urandom()));
               offer(access(ACT_WRITE, OFF_MAIN_LO, 1'b0, $urandom()));
            end
            if ($urandom_range(0, 1)) begin
               offer(access(ACT_WRITE, OFF_AUX_HI, 1'b1, $urandom()));
            end else begin
               offer(access(ACT_WRITE, OFF_AUX_HI, 1'b0, $urandom()));
               offer(access(ACT_WRITE, OFF_AUX_LO, 1'b0, $urandom()));
            end
            case ($urandom_range(0, 3))
               0: offer(access(ACT_WRITE, OFF_COUNT_HI, 1'b1, $urandom()));
               1: begin
                  offer(access(ACT_WRITE, OFF_COUNT_HI, 1'b0, $urandom()));
                  offer(access(ACT_WRITE, OFF_COUNT_LO, 1'b0, $urandom()));
               end
               2: begin
                  offer(access(ACT_WRITE, OFF_COUNT_LO, 1'b0, $urandom()));
                  offer(access(ACT_WRITE, OFF_COUNT_HI, 1'b0, $urandom()));
               end
               // Only one half: the request stays half armed until a later count write.
               default: offer(access(ACT_WRITE, $urandom_range(0, 1) ? OFF_COUNT_HI
                                                                     : OFF_COUNT_LO,
                                     1'b0, $urandom()));
            endcase
            if ($urandom_range(0, 1))
               offer(access(ACT_READ, OFF_CONTROL, 1'b0, $urandom()));
         end else if (pick < 55) begin
            offer(access(ACT_WRITE, OFF_CONTROL, 1'b0, $urandom()));
            n = $urandom_range(1, 3);
            repeat (n) offer(irq_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
         end else if (pick < 68) begin
            n = $urandom_range(1, 4);
            repeat (n) offer(irq_event(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1))));
         end else if (pick < 84) begin
            n = $urandom_range(1, 4);
            repeat (n)
               offer(access(ACT_READ, REG_MAP[$urandom_range(0, REG_COUNT - 1)],
                            $urandom_range(0, 4) == 0, $urandom()));
         end else if ($urandom_range(0, 1)) begin
            // Writes of either width to any mapped register, the read-only ones included.
            offer(access(ACT_WRITE, REG_MAP[$urandom_range(0, REG_COUNT - 1)],
                         1'($urandom_range(0, 1)), $urandom()));
         end else begin
            offer(access(2'($urandom_range(0, 3)), 16'($urandom()), 1'($urandom_range(0, 1)),
                         $urandom()));
         end
      end
      calm = 1'b0;
      req_ch.valid <= 1'b0;

      // The checker's pending count is registered, so step once before looking at it.
      do @(posedge clock); while (pending != 0);
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions, %0d of them reads, with %0d responses checked.",
               items_sent, read_count, responses_seen);
      $display("It saw %0d audio block fetches, %0d aux DMA requests and %0d raised irqs.",
               fetch_count, dma_count, irq_count);
      if (fail_count == 0 && pending == 0) begin
         $display("audio_and_aux_dma_interface_top: match");
      end else begin
         $display("audio_and_aux_dma_interface_top: mismatch");
      end
      $finish;
   end

endmodule
